// File: design/xo128p_pkg.sv
// ----------------------------------------------------------------------------
// xo128p_pkg: shared definitions for the xoshiro128+ generator core
// Holds the item operation codes, the generator constants and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package xo128p_pkg;

	localparam int unsigned FRACTION_BITS = 24;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned FRAC_OUT_W    = 24;

	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;
	localparam logic [31:0] MIX_MUL_A   = 32'h85eb_ca6b;
	localparam logic [31:0] MIX_MUL_B   = 32'hc2b2_ae35;

	typedef struct packed {
		logic       load_seed;
		logic       use_default;
		logic       latch_range;
		logic       mix_a;
		logic       mix_b;
		logic [1:0] word_idx;
		logic       step;
		logic       mul_lo;
		logic       mul_hi;
		logic       sum;
		logic       fin;
	} xo128p_cmd_t;

	typedef struct packed {
		logic seeded;
		logic out_free;
	} xo128p_status_t;

endpackage

// File: design/xoshiro128_plus_generator_core.sv
// ----------------------------------------------------------------------------
// xoshiro128_plus_generator_core: xoshiro128+ source with Q0.24 fraction scaling
//
//   channel  direction  handshake              payload
//   cfg      write      cfg_valid / cfg_ready  default_seed
//   item     in         item_valid/item_stall  op, seed_value, range_low/high
//   result   out        result_valid/stall     raw_value, fraction, scaled_value
//
// A seed item runs the shared mixer multiplier in a mix-A and a mix-B step
// for each of the four words. A draw steps the state, forms two 33x17 partial
// products, a wide sum and the final offset, after seeding first if needed.
// Reset clears the words, the seeded flag and the default seed. A stalled
// result sits in the output register; the next item is taken meanwhile and
// its result waits for that transfer before being written.
// ----------------------------------------------------------------------------
module xoshiro128_plus_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        default_seed,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               op,
	input  logic [31:0]        seed_value,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [31:0]        raw_value,
	output logic [23:0]        fraction,
	output logic signed [31:0] scaled_value
);
	import xo128p_pkg::*;

	xo128p_cmd_t    cmd;
	xo128p_status_t status;

	assign cfg_ready = 1'b1;

	xo128p_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.status     (status),
		.cmd        (cmd)
	);

	xo128p_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.default_seed (default_seed),
		.seed_value   (seed_value),
		.range_low    (range_low),
		.range_high   (range_high),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.raw_value    (raw_value),
		.fraction     (fraction),
		.scaled_value (scaled_value)
	);

endmodule

// File: design/xo128p_ctrl.sv
// ----------------------------------------------------------------------------
// xo128p_ctrl: sequencing controller
// Accepts one item at a time and steps the datapath through seeding (two
// shared multiplies per word) and drawing (state update, two partial
// products, a sum and the final offset).
// ----------------------------------------------------------------------------
module xo128p_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       op,
	input  xo128p_pkg::xo128p_status_t status,
	output xo128p_pkg::xo128p_cmd_t    cmd
);
	import xo128p_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MIX_A  = 3'd1;
	localparam logic [2:0] ST_MIX_B  = 3'd2;
	localparam logic [2:0] ST_STEP   = 3'd3;
	localparam logic [2:0] ST_MUL_LO = 3'd4;
	localparam logic [2:0] ST_MUL_HI = 3'd5;
	localparam logic [2:0] ST_SUM    = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       pend_q, pend_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		cmd     = '0;
		cmd.word_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					idx_d = 2'd0;
					if (op == OP_SEED) begin
						cmd.load_seed = 1'b1;
						pend_d        = 1'b0;
						state_d       = ST_MIX_A;
					end else begin
						cmd.latch_range = 1'b1;
						if (status.seeded) begin
							state_d = ST_STEP;
						end else begin
							cmd.load_seed   = 1'b1;
							cmd.use_default = 1'b1;
							pend_d          = 1'b1;
							state_d         = ST_MIX_A;
						end
					end
				end
			end
			ST_MIX_A: begin
				cmd.mix_a = 1'b1;
				state_d   = ST_MIX_B;
			end
			ST_MIX_B: begin
				cmd.mix_b = 1'b1;
				if (idx_q == 2'd3) begin
					state_d = pend_q ? ST_STEP : ST_IDLE;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = ST_MIX_A;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 2'd0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pend_q  <= pend_d;
		end
	end

	a_seed_then_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_seed |=> (state_q == ST_MIX_A) && (idx_q == 2'd0))
		else $error("seed load did not start the mixing sequence");

	a_step_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> status.seeded)
		else $error("generator stepped while not seeded");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> status.out_free)
		else $error("result written while the output register was occupied");

	a_seed_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_B) && (idx_q == 2'd3) && !pend_q |=> (state_q == ST_IDLE))
		else $error("seed-only item did not return to idle");

endmodule

// File: design/xo128p_datapath.sv
// ----------------------------------------------------------------------------
// xo128p_datapath: generator state, shared mixer multiplier and scaling
// Holds the four generator words, the default seed register, the range
// operands, the partial-product accumulator and the output register.
// ----------------------------------------------------------------------------
module xo128p_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  xo128p_pkg::xo128p_cmd_t    cmd,
	output xo128p_pkg::xo128p_status_t status,
	input  logic                       cfg_we,
	input  logic [31:0]                default_seed,
	input  logic [31:0]                seed_value,
	input  logic signed [31:0]         range_low,
	input  logic signed [31:0]         range_high,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [31:0]                raw_value,
	output logic [23:0]                fraction,
	output logic signed [31:0]         scaled_value
);
	import xo128p_pkg::*;

	logic [31:0]        words_q [4];
	logic               seeded_q;
	logic [31:0]        dseed_q;
	logic [31:0]        seed_q;
	logic [31:0]        mix_q;
	logic signed [31:0] lo_q;
	logic signed [32:0] diff_q;
	logic [31:0]        raw_q;
	logic [31:0]        frac_q;
	logic signed [49:0] prod_q;
	logic signed [49:0] acc_q;
	logic signed [64:0] sum_q;
	logic               out_valid_q;
	logic [31:0]        out_raw_q;
	logic [23:0]        out_frac_q;
	logic signed [31:0] out_scaled_q;

	logic [31:0] mult_in, mult_k, mult_p;
	logic [31:0] word_new;
	logic [31:0] draw_sum;
	logic [31:0] n0, n1, n2, n3;
	logic [31:0] seed_src;
	logic signed [16:0] chunk;
	logic signed [49:0] chunk_prod;

	assign mult_in  = cmd.mix_a ? (seed_q ^ (seed_q >> 16)) : (mix_q ^ (mix_q >> 13));
	assign mult_k   = cmd.mix_a ? MIX_MUL_A : MIX_MUL_B;
	assign mult_p   = mult_in * mult_k;
	assign word_new = mult_p ^ (mult_p >> 16);
	assign seed_src = cmd.use_default ? dseed_q : seed_value;

	assign draw_sum = words_q[0] + words_q[3];
	assign n2 = words_q[2] ^ words_q[0];
	assign n3 = words_q[3] ^ words_q[1];
	assign n1 = words_q[1] ^ n2;
	assign n0 = words_q[0] ^ n3;

	assign chunk      = cmd.mul_hi ? $signed({1'b0, frac_q[31:16]})
	                               : $signed({1'b0, frac_q[15:0]});
	assign chunk_prod = diff_q * chunk;

	assign status.seeded   = seeded_q;
	assign status.out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				words_q[i] <= '0;
			end
			seeded_q <= 1'b0;
			dseed_q  <= '0;
		end else begin
			if (cfg_we) begin
				dseed_q <= default_seed;
			end
			if (cmd.load_seed) begin
				seeded_q <= 1'b1;
			end
			if (cmd.mix_b) begin
				words_q[cmd.word_idx] <= word_new;
			end
			if (cmd.step) begin
				words_q[0] <= n0;
				words_q[1] <= n1;
				words_q[2] <= n2 ^ (words_q[1] << 9);
				words_q[3] <= {n3[20:0], n3[31:21]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			seed_q <= seed_src + GOLDEN_STEP;
		end else if (cmd.mix_b) begin
			seed_q <= seed_q + GOLDEN_STEP;
		end
		if (cmd.mix_a) begin
			mix_q <= mult_p;
		end
		if (cmd.latch_range) begin
			lo_q   <= range_low;
			diff_q <= 33'(range_high) - 33'(range_low);
		end
		if (cmd.step) begin
			raw_q  <= draw_sum;
			frac_q <= draw_sum >> (WORD_W - FRACTION_BITS);
		end
		if (cmd.mul_lo || cmd.mul_hi) begin
			prod_q <= chunk_prod;
		end
		if (cmd.mul_hi) begin
			acc_q <= prod_q;
		end
		if (cmd.sum) begin
			sum_q <= 65'(acc_q) + (65'(prod_q) <<< 16);
		end
		if (cmd.fin) begin
			out_raw_q    <= raw_q;
			out_frac_q   <= frac_q[FRAC_OUT_W-1:0];
			out_scaled_q <= lo_q + $signed(sum_q[FRACTION_BITS +: WORD_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign raw_value    = out_raw_q;
	assign fraction     = out_frac_q;
	assign scaled_value = out_scaled_q;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_stall |=> out_valid_q && $stable(out_scaled_q))
		else $error("stalled result was lost or changed");

	a_fraction_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_frac_q == 24'(out_raw_q >> (WORD_W - FRACTION_BITS)))
		else $error("fraction does not follow the raw value");

	a_seeded_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seeded flag cleared outside reset");

endmodule

// File: tb/xoshiro128_plus_generator_core_tb.sv
// ----------------------------------------------------------------------------
// xoshiro128_plus_generator_core_tb: self-checking bench for the generator core
// Seeds and draws through the item channel with random gaps on both sides.
// A scoreboard keeps its own copy of the four state words, the seeded flag
// and the default seed register, predicts every draw transfer and compares
// raw value, fraction and scaled value. The default seed register is written
// only while the core is idle, and the first draw arrives before any seed.
// ----------------------------------------------------------------------------
module xoshiro128_plus_generator_core_tb;

	import xo128p_pkg::*;

	typedef struct {
		logic [31:0] raw;
		logic [23:0] frac;
		logic [31:0] scaled;
	} draw_result_t;

	class draw_scoreboard;
		logic [31:0]  words [4];
		bit           seeded;
		logic [31:0]  fallback_seed;
		draw_result_t pending [$];
		int unsigned  errors;

		function new();
			for (int i = 0; i < 4; i++)
				words[i] = '0;
			seeded = 1'b0;
			fallback_seed = '0;
			errors = 0;
		endfunction

		function void note_config(logic [31:0] value);
			fallback_seed = value;
		endfunction

		function void fill_words(logic [31:0] s);
			logic [31:0] z;
			for (int i = 0; i < 4; i++) begin
				s = s + GOLDEN_STEP;
				z = s;
				z = (z ^ (z >> 16)) * MIX_MUL_A;
				z = (z ^ (z >> 13)) * MIX_MUL_B;
				words[i] = z ^ (z >> 16);
			end
			seeded = 1'b1;
		endfunction

		function void note_item(logic op_in, logic [31:0] seed_in,
				logic signed [31:0] lo, logic signed [31:0] hi);
			draw_result_t r;
			logic [31:0]  t;
			longint       span;
			longint       q;
			if (op_in == OP_SEED) begin
				fill_words(seed_in);
				return;
			end
			if (!seeded)
				fill_words(fallback_seed);
			r.raw = words[0] + words[3];
			t = words[1] << 9;
			words[2] ^= words[0];
			words[3] ^= words[1];
			words[1] ^= words[2];
			words[0] ^= words[3];
			words[2] ^= t;
			words[3] = {words[3][20:0], words[3][31:21]};
			r.frac = 24'(r.raw >> (WORD_W - FRACTION_BITS));
			// The signed product is exact in 64 bits, so an arithmetic shift floors it.
			span = longint'(hi) - longint'(lo);
			q = (span * longint'({8'd0, r.frac})) >>> FRACTION_BITS;
			r.scaled = 32'(longint'(lo) + q);
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] raw, logic [23:0] frac, logic [31:0] scaled);
			draw_result_t e;
			if (pending.size() == 0) begin
				$error("result transfer with no draw outstanding: raw_value %h", raw);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (raw !== e.raw) begin
				$error("raw_value expected %h actual %h", e.raw, raw);
				errors++;
			end
			if (frac !== e.frac) begin
				$error("fraction expected %h actual %h", e.frac, frac);
				errors++;
			end
			if (scaled !== e.scaled) begin
				$error("scaled_value expected %h actual %h", e.scaled, scaled);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [31:0]        default_seed = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               op = OP_SEED;
	logic [31:0]        seed_value = '0;
	logic signed [31:0] range_low = '0;
	logic signed [31:0] range_high = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [31:0]        raw_value;
	logic [23:0]        fraction;
	logic signed [31:0] scaled_value;

	draw_scoreboard board;
	bit             quiet = 1'b0;
	int unsigned    stall_left = 0;

	xoshiro128_plus_generator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.default_seed (default_seed),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.seed_value   (seed_value),
		.range_low    (range_low),
		.range_high   (range_high),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.raw_value    (raw_value),
		.fraction     (fraction),
		.scaled_value (scaled_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (quiet || sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_edge();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return 32'h0001_0000;
		endcase
	endfunction

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				board.check_result(raw_value, fraction, scaled_value);
			if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic op_in, logic [31:0] seed_in, logic [31:0] lo,
			logic [31:0] hi);
		int unsigned gap;
		item_valid <= 1'b1;
		op <= op_in;
		seed_value <= seed_in;
		range_low <= lo;
		range_high <= hi;
		do
			@(posedge clk);
		while (item_stall);
		board.note_item(op_in, seed_in, lo, hi);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_seed_reg(logic [31:0] value);
		cfg_valid <= 1'b1;
		default_seed <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.note_config(value);
	endtask

	task automatic random_item();
		logic        op_sel;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] lo;
		logic [31:0] hi;
		op_sel = ($urandom_range(0, 99) < 85) ? OP_DRAW : OP_SEED;
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 9))
			5: begin
				lo = a;
				hi = a;
			end
			6: begin
				lo = pick_edge();
				hi = pick_edge();
			end
			7: begin
				lo = a;
				hi = a + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			end
			8: begin
				lo = ($signed(a) < $signed(b)) ? b : a;
				hi = ($signed(a) < $signed(b)) ? a : b;
			end
			9: begin
				lo = ($signed(a) < $signed(b)) ? a : b;
				hi = ($signed(a) < $signed(b)) ? b : a;
			end
			default: begin
				lo = a;
				hi = b;
			end
		endcase
		send_item(op_sel, $urandom, lo, hi);
	endtask

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_seed_reg($urandom);

		// The first draw must seed itself from the default seed register.
		send_item(OP_DRAW, $urandom, 32'h0000_0000, 32'h0001_0000);
		send_item(OP_DRAW, $urandom, 32'h8000_0000, 32'h7fff_ffff);
		send_item(OP_DRAW, $urandom, 32'h7fff_ffff, 32'h8000_0000);
		send_item(OP_DRAW, $urandom, 32'h1234_5678, 32'h1234_5678);
		send_item(OP_DRAW, $urandom, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_DRAW, $urandom, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(OP_DRAW, $urandom, 32'h8000_0000, 32'h8000_0001);
		send_item(OP_DRAW, $urandom, 32'hffff_ffff, 32'h0000_0000);
		send_item(OP_DRAW, $urandom, 32'h0000_0000, 32'hffff_ffff);
		send_item(OP_SEED, 32'h0000_0000, $urandom, $urandom);
		send_item(OP_DRAW, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff);
		send_item(OP_DRAW, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_item(OP_SEED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(OP_DRAW, 32'hffff_ffff, 32'hff9c_0000, 32'h0064_0000);
		send_item(OP_DRAW, $urandom, 32'h0064_0000, 32'hff9c_0000);
		send_item(OP_SEED, $urandom, 32'h8000_0000, 32'h7fff_ffff);
		send_item(OP_SEED, $urandom, $urandom, $urandom);
		send_item(OP_DRAW, $urandom, 32'hffff_0000, 32'hfffe_0000);
		send_item(OP_DRAW, $urandom, 32'h8000_0000, 32'h0000_0000);
		send_item(OP_DRAW, $urandom, 32'h0000_0000, 32'h8000_0000);

		for (int p = 0; p < 4; p++) begin
			settle();
			write_seed_reg((p == 0) ? 32'h0000_0000 : (p == 1) ? 32'hffff_ffff : $urandom);
			quiet = (p == 2);
			repeat (250) random_item();
		end
		quiet = 1'b0;
		settle();

		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
